/* design/ppp_pkg.sv */
// Shared types and constants of the palette pixel packer.
// No dependencies; the interfaces and the packer top level use it.
`default_nettype none
package ppp_pkg;

	localparam int GROUP_PIXELS = 8;
	localparam int PIXEL_W      = 8;
	localparam int COLOUR_W     = 24;
	localparam int WORD_W       = 32;
	localparam int PAL_DEPTH    = 256;
	localparam int PAL_AW       = $clog2(PAL_DEPTH);
	localparam int SEL_W        = $clog2(GROUP_PIXELS);
	localparam int INST_W       = SEL_W + 1;

	typedef enum logic [1:0] {
		DEPTH_8BPP  = 2'd0,
		DEPTH_16BPP = 2'd1,
		DEPTH_24BPP = 2'd2,
		DEPTH_32BPP = 2'd3
	} depth_t;

	typedef enum logic {
		MODE_PAL_WRITE = 1'b0,
		MODE_CONVERT   = 1'b1
	} mode_t;

	localparam depth_t DEPTH_RESET = DEPTH_32BPP;

endpackage
`default_nettype wire

/* design/ppp_item_if.sv */
// Input channel of the packer: one group of palette indices or one palette write.
// Depends on ppp_pkg for field widths.
`default_nettype none
interface ppp_item_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic                          hires;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_0;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_1;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_2;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_3;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_4;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_5;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_6;
	logic [ppp_pkg::PIXEL_W-1:0]   pixel_7;
	logic [ppp_pkg::PAL_AW-1:0]    palette_index;
	logic [ppp_pkg::COLOUR_W-1:0]  palette_value;

	modport source (
		output valid, mode, hires, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7, palette_index, palette_value,
		input  ready
	);
	modport sink (
		input  valid, mode, hires, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7, palette_index, palette_value,
		output ready
	);
endinterface
`default_nettype wire

/* design/ppp_word_if.sv */
// Output channel of the packer: one packed framebuffer word per beat.
// Depends on ppp_pkg for the word width.
`default_nettype none
interface ppp_word_if;
	logic                        valid;
	logic                        ready;
	logic [ppp_pkg::WORD_W-1:0]  packed_word;
	logic                        last_word;

	modport source (output valid, packed_word, last_word, input ready);
	modport sink   (input valid, packed_word, last_word, output ready);
endinterface
`default_nettype wire

/* design/ppp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ppp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* design/palette_pixel_packer.sv */
// Top level of the palette pixel packer: sequencer, palette RAM, colour and packing stages.
// Depends on ppp_pkg, ppp_item_if, ppp_word_if and ppp_ram.
//
// Each group of eight palette indices is walked one pixel instance per cycle, unless the
// output stalls: eight instances for a high-resolution group, sixteen for a low-resolution
// one (each pixel twice). The rate is set by the single read port of the palette RAM,
// which serves one lookup per instance. Each instance adds 1 to 4 bytes to a byte
// accumulator and at most one 32-bit word leaves per cycle; a group yields 2 to 16
// words, the last one flagged. The last instance passes the stage 1 (palette lookup),
// stage 2 and stage 3 registers before its word leaves. The whole pipeline stalls
// together while a word waits at the output.
// Colour depth must only be changed while the block is empty; palette entries read
// before they are written give undefined colours.
`default_nettype none
module palette_pixel_packer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_wdata,
	ppp_item_if.sink                   items,
	ppp_word_if.source                 words
);
	import ppp_pkg::*;

	depth_t                depth_q;
	logic                  busy_q;
	mode_t                 mode_q;
	logic                  hires_q;
	logic [PIXEL_W-1:0]    pix_q [GROUP_PIXELS];
	logic [PAL_AW-1:0]     pidx_q;
	logic [COLOUR_W-1:0]   pval_q;
	logic [INST_W-1:0]     inst_q;

	logic                  adv;
	logic                  last_inst;
	logic                  seq_done;
	logic                  take;
	logic                  pal_we;
	logic                  rd_issue;
	logic [SEL_W-1:0]      sel;
	logic [PIXEL_W-1:0]    cur_pix;

	logic                  v_s1;
	logic                  last_s1;
	logic [PIXEL_W-1:0]    index_s1;
	logic [COLOUR_W-1:0]   colour_s1;

	logic                  v_s2;
	logic                  last_s2;
	logic [WORD_W-1:0]     px_s2;

	logic [COLOUR_W-1:0]   acc_q;
	logic [1:0]            fill_q;
	logic [2:0]            nbytes;
	logic [2:0]            sum;
	logic [WORD_W+COLOUR_W-1:0] merged;

	logic                  v_s3;
	logic                  last_s3;
	logic [WORD_W-1:0]     word_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= depth_t'(cfg_wdata);
		end
	end

	// sequencer
	assign adv       = !v_s3 || words.ready;
	assign sel       = hires_q ? inst_q[SEL_W-1:0] : inst_q[INST_W-1:1];
	assign cur_pix   = pix_q[sel];
	assign last_inst = hires_q ? (&inst_q[SEL_W-1:0]) : (&inst_q);
	assign seq_done  = (mode_q == MODE_PAL_WRITE) || last_inst;
	assign items.ready = adv && (!busy_q || seq_done);
	assign take      = items.valid && items.ready;
	assign pal_we    = adv && busy_q && (mode_q == MODE_PAL_WRITE);
	assign rd_issue  = adv && busy_q && (mode_q == MODE_CONVERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			inst_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			inst_q <= '0;
		end else if (adv && busy_q) begin
			if (seq_done) begin
				busy_q <= 1'b0;
			end else begin
				inst_q <= inst_q + INST_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_q   <= mode_t'(items.mode);
			hires_q  <= items.hires;
			pix_q[0] <= items.pixel_0;
			pix_q[1] <= items.pixel_1;
			pix_q[2] <= items.pixel_2;
			pix_q[3] <= items.pixel_3;
			pix_q[4] <= items.pixel_4;
			pix_q[5] <= items.pixel_5;
			pix_q[6] <= items.pixel_6;
			pix_q[7] <= items.pixel_7;
			pidx_q   <= items.palette_index;
			pval_q   <= items.palette_value;
		end
	end

	ppp_ram #(
		.WIDTH (COLOUR_W),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pidx_q),
		.wdata (pval_q),
		.re    (rd_issue),
		.raddr (cur_pix),
		.rdata (colour_s1)
	);

	// stage 1: palette lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			last_s1  <= last_inst;
			index_s1 <= cur_pix;
		end
	end

	// stage 2: pixel colour in output format
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			last_s2 <= last_s1;
			unique case (depth_q)
				DEPTH_8BPP:  px_s2 <= {{(WORD_W-PIXEL_W){1'b0}}, index_s1};
				DEPTH_16BPP: px_s2 <= {{(WORD_W-16){1'b0}}, colour_s1[15:0]};
				DEPTH_24BPP: px_s2 <= {{(WORD_W-COLOUR_W){1'b0}}, colour_s1};
				DEPTH_32BPP: px_s2 <= {{(WORD_W-COLOUR_W){1'b0}}, colour_s1};
				default:     px_s2 <= '0;
			endcase
		end
	end

	// stage 3: byte packing
	assign nbytes = {1'b0, depth_q} + 3'd1;
	assign sum    = {1'b0, fill_q} + nbytes;

	always_comb begin
		merged = {{WORD_W{1'b0}}, acc_q};
		case (fill_q)
			2'd0:    merged = {{COLOUR_W{1'b0}}, px_s2};
			2'd1:    merged = merged | {{(COLOUR_W-8){1'b0}}, px_s2, 8'd0};
			2'd2:    merged = merged | {{(COLOUR_W-16){1'b0}}, px_s2, 16'd0};
			default: merged = merged | {px_s2, 24'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			v_s3   <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2 && sum[2];
			if (v_s2) begin
				fill_q <= sum[1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q   <= sum[2] ? merged[WORD_W+COLOUR_W-1:WORD_W] : merged[COLOUR_W-1:0];
			word_s3 <= merged[WORD_W-1:0];
			last_s3 <= last_s2;
		end
	end

	assign words.valid       = v_s3;
	assign words.packed_word = word_s3;
	assign words.last_word   = last_s3;

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && last_s2) |=> (fill_q == 2'd0))
		else $error("accumulator not empty after last instance");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && last_s2) |=> (v_s3 && last_s3))
		else $error("last instance of a group gave no word");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(pal_we && rd_issue))
		else $error("palette write and read issued together");

	a_stall_holds_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && busy_q) |=> ($stable(inst_q) && busy_q))
		else $error("sequencer advanced during stall");
endmodule
`default_nettype wire

/* test/tb_palette_pixel_packer.sv */
// Testbench for palette_pixel_packer: directed table, then random groups and palette writes
// at every colour depth, with each packed word checked against an in-bench predictor.
// Depends on ppp_pkg, ppp_item_if, ppp_word_if and the packer RTL.
`timescale 1ns / 1ps
module tb_palette_pixel_packer;
	import ppp_pkg::*;

	typedef struct packed {
		depth_t        depth;
		mode_t         mode;
		logic          hires;
		logic [63:0]   pixels;
		logic [7:0]    pidx;
		logic [23:0]   pval;
		logic          typed;
		logic [31:0]   fill;
	} pix_item_t;

	typedef struct packed {
		logic [31:0]   word;
		logic          last;
	} word_exp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	ppp_item_if items_ch ();
	ppp_word_if words_ch ();

	palette_pixel_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch),
		.words     (words_ch)
	);

	word_exp_t    pending_words [$];
	logic [23:0]  pal_shadow [PAL_DEPTH];
	bit           pal_written [PAL_DEPTH];
	logic [7:0]   written_idx [$];
	depth_t       cur_depth = DEPTH_RESET;
	int           errors = 0;
	bit           src_calm = 1'b0;
	bit           snk_calm = 1'b0;

	pix_item_t dir_tab [20] = '{
		'{DEPTH_32BPP, MODE_PAL_WRITE, 1'b0, 64'h0, 8'h00, 24'h000000, 1'b0, 32'h0},
		'{DEPTH_32BPP, MODE_PAL_WRITE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 24'hFFFFFF,
			1'b0, 32'h0},
		'{DEPTH_32BPP, MODE_PAL_WRITE, 1'b0, 64'h0, 8'h5A, 24'h123456, 1'b0, 32'h0},
		'{DEPTH_32BPP, MODE_PAL_WRITE, 1'b0, 64'h0, 8'hA5, 24'hABCDEF, 1'b0, 32'h0},
		'{DEPTH_32BPP, MODE_CONVERT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 24'h000000,
			1'b1, 32'h00FF_FFFF},
		'{DEPTH_32BPP, MODE_CONVERT, 1'b0, 64'h0, 8'hFF, 24'hFFFFFF, 1'b1, 32'h0},
		'{DEPTH_32BPP, MODE_CONVERT, 1'b1, 64'h00FF_5AA5_A55A_FF00, 8'hFF, 24'hFFFFFF,
			1'b0, 32'h0},
		'{DEPTH_32BPP, MODE_CONVERT, 1'b0, 64'h5AA5_00FF_FF00_A55A, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_8BPP, MODE_CONVERT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 24'h0,
			1'b1, 32'hFFFF_FFFF},
		'{DEPTH_8BPP, MODE_CONVERT, 1'b0, 64'h0, 8'h00, 24'h0, 1'b1, 32'h0},
		'{DEPTH_8BPP, MODE_CONVERT, 1'b1, 64'h8040_2010_0804_0201, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_8BPP, MODE_CONVERT, 1'b0, 64'h0102_0408_1020_4080, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_16BPP, MODE_CONVERT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 24'h0,
			1'b1, 32'hFFFF_FFFF},
		'{DEPTH_16BPP, MODE_CONVERT, 1'b0, 64'h5AA5_00FF_5AA5_00FF, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_16BPP, MODE_PAL_WRITE, 1'b0, 64'h0, 8'h5A, 24'hFEDCBA, 1'b0, 32'h0},
		'{DEPTH_16BPP, MODE_CONVERT, 1'b1, 64'h5A5A_A5A5_0000_FFFF, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_24BPP, MODE_CONVERT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 24'h0,
			1'b1, 32'hFFFF_FFFF},
		'{DEPTH_24BPP, MODE_CONVERT, 1'b0, 64'h0, 8'h00, 24'h0, 1'b1, 32'h0},
		'{DEPTH_24BPP, MODE_CONVERT, 1'b1, 64'h00FF_5AA5_A55A_FF00, 8'h00, 24'h0, 1'b0, 32'h0},
		'{DEPTH_24BPP, MODE_CONVERT, 1'b0, 64'hA55A_FF00_5AA5_00FF, 8'h00, 24'h0, 1'b0, 32'h0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic pack_expected(input pix_item_t it);
		logic [7:0]   stream [$];
		logic [23:0]  colour;
		logic [7:0]   ix;
		word_exp_t    w_exp;
		int           reps, nbytes, nwords, p, r, b, w;
		if (it.mode == MODE_PAL_WRITE) begin
			pal_shadow[it.pidx] = it.pval;
			if (!pal_written[it.pidx]) begin
				pal_written[it.pidx] = 1'b1;
				written_idx.push_back(it.pidx);
			end
			return;
		end
		reps = it.hires ? 1 : 2;
		nbytes = int'(cur_depth) + 1;
		for (p = 0; p < GROUP_PIXELS; p++) begin
			ix = it.pixels[8*p +: 8];
			case (cur_depth)
				DEPTH_8BPP:  colour = {16'h0, ix};
				DEPTH_16BPP: colour = {8'h0, pal_shadow[ix][15:0]};
				default:     colour = pal_shadow[ix];
			endcase
			for (r = 0; r < reps; r++)
				for (b = 0; b < nbytes; b++)
					stream.push_back(b < 3 ? colour[8*b +: 8] : 8'h00);
		end
		nwords = stream.size() / 4;
		for (w = 0; w < nwords; w++) begin
			w_exp.word = {stream[4*w+3], stream[4*w+2], stream[4*w+1], stream[4*w]};
			w_exp.last = (w == nwords - 1);
			pending_words.push_back(w_exp);
		end
	endtask

	task automatic drive_item(input pix_item_t it);
		int gap, nwords, w;
		word_exp_t w_exp;
		if ($urandom_range(0, 11) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_ch.valid         <= 1'b1;
		items_ch.mode          <= it.mode;
		items_ch.hires         <= it.hires;
		items_ch.pixel_0       <= it.pixels[7:0];
		items_ch.pixel_1       <= it.pixels[15:8];
		items_ch.pixel_2       <= it.pixels[23:16];
		items_ch.pixel_3       <= it.pixels[31:24];
		items_ch.pixel_4       <= it.pixels[39:32];
		items_ch.pixel_5       <= it.pixels[47:40];
		items_ch.pixel_6       <= it.pixels[55:48];
		items_ch.pixel_7       <= it.pixels[63:56];
		items_ch.palette_index <= it.pidx;
		items_ch.palette_value <= it.pval;
		do @(posedge clk); while (!items_ch.ready);
		if (it.typed && it.mode == MODE_CONVERT) begin
			nwords = 8 * (int'(cur_depth) + 1) * (it.hires ? 1 : 2) / 4;
			for (w = 0; w < nwords; w++) begin
				w_exp.word = it.fill;
				w_exp.last = (w == nwords - 1);
				pending_words.push_back(w_exp);
			end
		end else begin
			pack_expected(it);
		end
	endtask

	task automatic set_depth(input depth_t d);
		items_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_depth = d;
	endtask

	initial begin
		int stall;
		word_exp_t want;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 15) == 0)
				snk_calm = !snk_calm;
			stall = snk_calm ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				words_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			words_ch.ready <= 1'b1;
			do @(posedge clk); while (!words_ch.valid);
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word %h with none outstanding", words_ch.packed_word));
			end else begin
				want = pending_words.pop_front();
				if (words_ch.packed_word !== want.word)
					report_mismatch($sformatf("packed_word %h, predicted %h",
						words_ch.packed_word, want.word));
				if (words_ch.last_word !== want.last)
					report_mismatch($sformatf("last_word %b, predicted %b",
						words_ch.last_word, want.last));
			end
		end
	end

	initial begin
		int i, ph, k;
		pix_item_t it;
		depth_t ph_depth;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= '0;
		items_ch.valid         <= 1'b0;
		items_ch.mode          <= MODE_PAL_WRITE;
		items_ch.hires         <= 1'b0;
		items_ch.pixel_0       <= '0;
		items_ch.pixel_1       <= '0;
		items_ch.pixel_2       <= '0;
		items_ch.pixel_3       <= '0;
		items_ch.pixel_4       <= '0;
		items_ch.pixel_5       <= '0;
		items_ch.pixel_6       <= '0;
		items_ch.pixel_7       <= '0;
		items_ch.palette_index <= '0;
		items_ch.palette_value <= '0;
		words_ch.ready         <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_tab); i++) begin
			if (dir_tab[i].depth != cur_depth)
				set_depth(dir_tab[i].depth);
			drive_item(dir_tab[i]);
		end

		for (ph = 0; ph < 6; ph++) begin
			ph_depth = (ph < 4) ? depth_t'(ph) : depth_t'($urandom_range(0, 3));
			set_depth(ph_depth);
			for (i = 0; i < 13; i++) begin
				it.depth = cur_depth;
				it.mode  = ($urandom_range(0, 3) == 0) ? MODE_PAL_WRITE : MODE_CONVERT;
				it.hires = 1'($urandom_range(0, 1));
				for (k = 0; k < GROUP_PIXELS; k++)
					it.pixels[8*k +: 8] = (cur_depth == DEPTH_8BPP) ? 8'($urandom_range(0, 255))
						: written_idx[$urandom_range(0, written_idx.size() - 1)];
				it.pidx  = 8'($urandom_range(0, 255));
				it.pval  = 24'($urandom_range(0, 24'hFFFFFF));
				it.typed = 1'b0;
				it.fill  = '0;
				drive_item(it);
			end
		end

		items_ch.valid <= 1'b0;
		for (i = 0; i < 4000 && pending_words.size() != 0; i++)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
